// File: sv/okvt_pkg.sv
// ---------------------------------------------------------------------------
// okvt_pkg
// Shared widths, request codes, sequencer states and cell control word for
// the ordered key/value table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package okvt_pkg;

  localparam int DEPTH      = 256;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int FUNC_W  = 3;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;
  localparam int CAP_W   = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT   = 3'd0,
    FN_UPDATE   = 3'd1,
    FN_INS_UPD  = 3'd2,
    FN_ERASE    = 3'd3,
    FN_CONTAINS = 3'd4,
    FN_GET_KEY  = 3'd5,
    FN_GET_IDX  = 3'd6
  } func_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic                  cmp;
    logic                  ins;
    logic                  upd;
    logic                  shift;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [INDEX_W-1:0]    index;
    logic [CNT_W-1:0]      count;
    logic [IDX_W-1:0]      slot;
  } ctl_t;

endpackage

`default_nettype wire

// File: sv/okvt_if.sv
// ---------------------------------------------------------------------------
// okvt request and response channels
// Valid/ready channels carrying one request word and one response word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface okvt_req_if;
  logic                            valid;
  logic                            ready;
  logic [okvt_pkg::FUNC_W-1:0]     func;
  logic [okvt_pkg::KEY_W-1:0]      key;
  logic [okvt_pkg::VALUE_W-1:0]    value;
  logic [okvt_pkg::INDEX_W-1:0]    index;

  modport source (output valid, func, key, value, index, input ready);
  modport sink   (input valid, func, key, value, index, output ready);
endinterface

interface okvt_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [okvt_pkg::KEY_W-1:0]      key_out;
  logic [okvt_pkg::VALUE_W-1:0]    value_out;
  logic [okvt_pkg::COUNT_W-1:0]    count;
  logic                            is_empty;

  modport source (output valid, ok, key_out, value_out, count, is_empty, input ready);
  modport sink   (input valid, ok, key_out, value_out, count, is_empty, output ready);
endinterface

`default_nettype wire

// File: sv/okvt_cell.sv
// ---------------------------------------------------------------------------
// okvt_cell
// One table slot: holds a pair, compares it against the broadcast key and
// index, and takes its upper neighbor's pair when an erase closes the gap.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okvt_cell (
  input  wire logic                                clk,
  input  wire logic [okvt_pkg::IDX_W-1:0]          pos,
  input  wire okvt_pkg::ctl_t                      ctl,
  input  wire logic [okvt_pkg::KEY_BITS-1:0]       nb_key,
  input  wire logic [okvt_pkg::VALUE_BITS-1:0]     nb_value,
  output logic [okvt_pkg::KEY_BITS-1:0]            key_r,
  output logic [okvt_pkg::VALUE_BITS-1:0]          value_r,
  output logic                                     hit_r,
  output logic                                     sel_r
);

  logic occupied;
  logic at_top;
  logic at_or_above;

  assign occupied    = okvt_pkg::CNT_W'(pos) < ctl.count;
  assign at_top      = okvt_pkg::CNT_W'(pos) == ctl.count;
  assign at_or_above = pos >= ctl.slot;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit_r <= occupied && (key_r == ctl.key);
      sel_r <= occupied && (32'(pos) == 32'(ctl.index));
    end
    if (ctl.ins && at_top) begin
      key_r   <= ctl.key;
      value_r <= ctl.value;
    end else if (ctl.upd && hit_r) begin
      value_r <= ctl.value;
    end else if (ctl.shift && at_or_above) begin
      key_r   <= nb_key;
      value_r <= nb_value;
    end
  end

endmodule

`default_nettype wire

// File: sv/okvt_gather.sv
// ---------------------------------------------------------------------------
// okvt_gather
// Fold the cell match flags into the matching slot, its value, and the pair
// at the requested position.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okvt_gather (
  input  wire logic [okvt_pkg::DEPTH-1:0]          hit,
  input  wire logic [okvt_pkg::DEPTH-1:0]          sel,
  input  wire logic [okvt_pkg::KEY_BITS-1:0]       keys   [okvt_pkg::DEPTH],
  input  wire logic [okvt_pkg::VALUE_BITS-1:0]     values [okvt_pkg::DEPTH],
  output logic                                     found,
  output logic [okvt_pkg::IDX_W-1:0]               slot,
  output logic [okvt_pkg::VALUE_BITS-1:0]          hit_value,
  output logic                                     sel_found,
  output logic [okvt_pkg::KEY_BITS-1:0]            sel_key,
  output logic [okvt_pkg::VALUE_BITS-1:0]          sel_value
);

  always_comb begin
    found     = |hit;
    sel_found = |sel;
    slot      = '0;
    hit_value = '0;
    sel_key   = '0;
    sel_value = '0;
    for (int i = 0; i < okvt_pkg::DEPTH; i++) begin
      slot      = slot | (okvt_pkg::IDX_W'(i) & {okvt_pkg::IDX_W{hit[i]}});
      hit_value = hit_value | (values[i] & {okvt_pkg::VALUE_BITS{hit[i]}});
      sel_key   = sel_key | (keys[i] & {okvt_pkg::KEY_BITS{sel[i]}});
      sel_value = sel_value | (values[i] & {okvt_pkg::VALUE_BITS{sel[i]}});
    end
  end

endmodule

`default_nettype wire

// File: sv/ordered_key_value_table_core.sv
// ---------------------------------------------------------------------------
// ordered_key_value_table_core
// Key/value table with unique keys in insertion order, one slot per cell.
//
// in_word carries a request (func, key, value, index); out_word returns one
// response word per request (ok, key_out, value_out, count, is_empty).
// cfg_data is written to the capacity register at any rising edge with cfg_we high, outside reset.
// A request runs as a compare step and an act step: in the accept cycle every
// cell compares its key and position against the request; in the act step
// the match flags are folded, the cells insert, update or shift, and the
// response register loads. One request is in flight at a time: a new request
// is not taken until the last one has loaded its response word.
// The response register parts the two sides: a stalled receiver holds the
// response word and the pending request waits in its act cycle until the
// word is taken; in_word.ready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the table, sets capacity to 256
// and drops any pending response. Slot contents are not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_key_value_table_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  okvt_req_if.sink                        in_word,
  okvt_rsp_if.source                      out_word,
  input  wire logic                       cfg_we,
  input  wire logic [okvt_pkg::CAP_W-1:0] cfg_data
);

  okvt_pkg::state_t                   state_r, state_nxt;
  logic [okvt_pkg::CAP_W-1:0]         cap_r;
  logic [okvt_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [okvt_pkg::CNT_W-1:0]         eff_cap;

  logic [okvt_pkg::FUNC_W-1:0]        req_func_r;
  logic [okvt_pkg::KEY_BITS-1:0]      req_key_r;
  logic [okvt_pkg::VALUE_BITS-1:0]    req_value_r;

  logic                               out_valid_r;
  logic                               out_ok_r, out_ok_nxt;
  logic [okvt_pkg::KEY_W-1:0]         out_key_r, out_key_nxt;
  logic [okvt_pkg::VALUE_W-1:0]       out_value_r, out_value_nxt;
  logic [okvt_pkg::COUNT_W-1:0]       out_count_r;
  logic                               out_empty_r;

  logic                               accept;
  logic                               go;
  logic                               room;
  okvt_pkg::ctl_t                     ctl;

  logic [okvt_pkg::KEY_BITS-1:0]      cell_key   [okvt_pkg::DEPTH];
  logic [okvt_pkg::VALUE_BITS-1:0]    cell_value [okvt_pkg::DEPTH];
  logic [okvt_pkg::DEPTH-1:0]         cell_hit;
  logic [okvt_pkg::DEPTH-1:0]         cell_sel;

  logic                               found;
  logic [okvt_pkg::IDX_W-1:0]         slot;
  logic [okvt_pkg::VALUE_BITS-1:0]    hit_value;
  logic                               sel_found;
  logic [okvt_pkg::KEY_BITS-1:0]      sel_key;
  logic [okvt_pkg::VALUE_BITS-1:0]    sel_value;

  assign in_word.ready      = (state_r == okvt_pkg::S_IDLE);
  assign accept             = in_word.valid && in_word.ready;
  assign go                 = (state_r == okvt_pkg::S_EXEC) && (!out_valid_r || out_word.ready);

  assign out_word.valid     = out_valid_r;
  assign out_word.ok        = out_ok_r;
  assign out_word.key_out   = out_key_r;
  assign out_word.value_out = out_value_r;
  assign out_word.count     = out_count_r;
  assign out_word.is_empty  = out_empty_r;

  always_comb begin
    if (32'(cap_r) > 32'(okvt_pkg::DEPTH)) begin
      eff_cap = okvt_pkg::CNT_W'(okvt_pkg::DEPTH);
    end else begin
      eff_cap = okvt_pkg::CNT_W'(cap_r);
    end
  end

  assign room = count_r < eff_cap;

  // cell row
  for (genvar i = 0; i < okvt_pkg::DEPTH; i++) begin : g_cell
    logic [okvt_pkg::KEY_BITS-1:0]   nb_key;
    logic [okvt_pkg::VALUE_BITS-1:0] nb_value;

    if (i == okvt_pkg::DEPTH - 1) begin : g_last
      assign nb_key   = '0;
      assign nb_value = '0;
    end else begin : g_mid
      assign nb_key   = cell_key[i+1];
      assign nb_value = cell_value[i+1];
    end

    okvt_cell u_cell (
      .clk      (clk),
      .pos      (okvt_pkg::IDX_W'(i)),
      .ctl      (ctl),
      .nb_key   (nb_key),
      .nb_value (nb_value),
      .key_r    (cell_key[i]),
      .value_r  (cell_value[i]),
      .hit_r    (cell_hit[i]),
      .sel_r    (cell_sel[i])
    );
  end

  okvt_gather u_gather (
    .hit       (cell_hit),
    .sel       (cell_sel),
    .keys      (cell_key),
    .values    (cell_value),
    .found     (found),
    .slot      (slot),
    .hit_value (hit_value),
    .sel_found (sel_found),
    .sel_key   (sel_key),
    .sel_value (sel_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= okvt_pkg::S_IDLE;
      cap_r       <= okvt_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func_r  <= in_word.func;
      req_key_r   <= okvt_pkg::KEY_BITS'(in_word.key);
      req_value_r <= okvt_pkg::VALUE_BITS'(in_word.value);
    end
    if (go) begin
      out_ok_r    <= out_ok_nxt;
      out_key_r   <= out_key_nxt;
      out_value_r <= out_value_nxt;
      out_count_r <= okvt_pkg::COUNT_W'(count_nxt);
      out_empty_r <= (count_nxt == '0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_ok_nxt    = 1'b0;
    out_key_nxt   = '0;
    out_value_nxt = '0;

    ctl       = '0;
    ctl.count = count_r;
    ctl.slot  = slot;

    case (state_r)
      okvt_pkg::S_IDLE: begin
        ctl.cmp   = accept;
        ctl.key   = okvt_pkg::KEY_BITS'(in_word.key);
        ctl.index = in_word.index;
        if (accept) begin
          state_nxt = okvt_pkg::S_EXEC;
        end
      end
      okvt_pkg::S_EXEC: begin
        ctl.key   = req_key_r;
        ctl.value = req_value_r;
        case (req_func_r)
          okvt_pkg::FN_INSERT: begin
            out_ok_nxt = !found && room;
            ctl.ins    = !found && room;
          end
          okvt_pkg::FN_UPDATE: begin
            out_ok_nxt = found;
            ctl.upd    = found;
          end
          okvt_pkg::FN_INS_UPD: begin
            out_ok_nxt = found || room;
            ctl.upd    = found;
            ctl.ins    = !found && room;
          end
          okvt_pkg::FN_ERASE: begin
            out_ok_nxt = found;
            ctl.shift  = found;
          end
          okvt_pkg::FN_CONTAINS: begin
            out_ok_nxt = found;
          end
          okvt_pkg::FN_GET_KEY: begin
            out_ok_nxt    = found;
            out_value_nxt = okvt_pkg::VALUE_W'(hit_value);
          end
          okvt_pkg::FN_GET_IDX: begin
            out_ok_nxt    = sel_found;
            out_key_nxt   = okvt_pkg::KEY_W'(sel_key);
            out_value_nxt = okvt_pkg::VALUE_W'(sel_value);
          end
          default: begin
            out_ok_nxt = 1'b0;
          end
        endcase
        // hold everything until the response register is free
        if (!go) begin
          ctl.ins   = 1'b0;
          ctl.upd   = 1'b0;
          ctl.shift = 1'b0;
        end else begin
          state_nxt = okvt_pkg::S_IDLE;
          if (ctl.ins) begin
            count_nxt = count_r + okvt_pkg::CNT_W'(1);
          end else if (ctl.shift) begin
            count_nxt = count_r - okvt_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = okvt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/okvt_checker.sv
// ---------------------------------------------------------------------------
// okvt_checker
// Port-level checks for the ordered key/value table, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okvt_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [okvt_pkg::COUNT_W-1:0] out_count,
  input wire logic                         out_is_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response word dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("response word without a request two cycles before");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_count) <= 32'(okvt_pkg::DEPTH)))
    else $error("count exceeds table depth");

endmodule

bind ordered_key_value_table_core okvt_checker u_okvt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_word.valid),
  .in_ready     (in_word.ready),
  .out_valid    (out_word.valid),
  .out_ready    (out_word.ready),
  .out_count    (out_word.count),
  .out_is_empty (out_word.is_empty)
);

`default_nettype wire
